// ----- hdl/smi_pkg.sv -----
// Shared types and constants of the small matrix inverse core.
// Used by every module under hdl; depends on nothing.
package smi_pkg;

	localparam int FRAC_BITS = 16;

	localparam int EW   = 32;              // element width
	localparam int NE   = 9;               // elements per matrix
	localparam int PW   = 2 * EW;          // element product
	localparam int CW   = PW + 1;          // cofactor
	localparam int DW   = CW + EW;         // determinant, signed
	localparam int NW   = EW + 34;         // selected numerator, signed
	localparam int MAGW = 64;              // numerator magnitude
	localparam int DMW  = DW - 1;          // divisor magnitude
	localparam int QW   = EW + 1;          // quotient bits incl. round bit
	localparam int SH   = 2 * FRAC_BITS + 1;
	localparam int MW   = MAGW + SH;       // scaled dividend

	localparam logic [1:0] SIZE_NONE = 2'd0;
	localparam logic [1:0] SIZE_1    = 2'd1;
	localparam logic [1:0] SIZE_2    = 2'd2;
	localparam logic [1:0] SIZE_3    = 2'd3;

	localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (EW - 1)) - 64'd1);
	localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (EW - 1));

	typedef logic signed [EW-1:0] elem_t;
	typedef logic signed [CW-1:0] cof_t;
	typedef logic signed [DW-1:0] det_t;
	typedef logic signed [NW-1:0] num_t;

	typedef struct packed {
		logic [1:0]       size;
		elem_t [NE-1:0]   a;
	} mat_t;

endpackage

// ----- hdl/smi_cof.sv -----
// Element products and the nine 2x2 cofactors (two register stages).
// Depends on smi_pkg.
module smi_cof (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     valid,
	input  smi_pkg::mat_t            mat,
	output logic                     cof_valid,
	output smi_pkg::mat_t            cof_mat,
	output smi_pkg::cof_t            cof [smi_pkg::NE]
);
	import smi_pkg::*;

	logic                    v_s1, v_s2;
	mat_t                    mat_s1, mat_s2;
	logic signed [PW-1:0]    pp_s1 [NE];
	logic signed [PW-1:0]    pm_s1 [NE];
	cof_t                    cof_s2 [NE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat_s1 <= mat;
			mat_s2 <= mat_s1;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			localparam int R1 = (i + 1) % 3;
			localparam int R2 = (i + 2) % 3;
			localparam int C1 = (j + 1) % 3;
			localparam int C2 = (j + 2) % 3;
			elem_t e11, e22, e12, e21;
			assign e11 = $signed(mat.a[R1*3+C1]);
			assign e22 = $signed(mat.a[R2*3+C2]);
			assign e12 = $signed(mat.a[R1*3+C2]);
			assign e21 = $signed(mat.a[R2*3+C1]);
			always_ff @(posedge clk) begin
				if (en) begin
					pp_s1[i*3+j]  <= e11 * e22;
					pm_s1[i*3+j]  <= e12 * e21;
					cof_s2[i*3+j] <= cof_t'(pp_s1[i*3+j]) - cof_t'(pm_s1[i*3+j]);
				end
			end
			assign cof[i*3+j] = cof_s2[i*3+j];
		end
	end

	assign cof_valid = v_s2;
	assign cof_mat   = mat_s2;

endmodule

// ----- hdl/smi_det.sv -----
// 3x3 determinant by expansion along row 0, 32x65 products split in halves
// (three register stages). Depends on smi_pkg.
module smi_det (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     valid,
	input  smi_pkg::mat_t            mat,
	input  smi_pkg::cof_t            cof [smi_pkg::NE],
	output logic                     det_valid,
	output smi_pkg::mat_t            det_mat,
	output smi_pkg::cof_t            det_cof [smi_pkg::NE],
	output smi_pkg::det_t            det
);
	import smi_pkg::*;

	logic                    v_s3, v_s4, v_s5;
	mat_t                    mat_s3, mat_s4, mat_s5;
	cof_t                    cof_s3 [NE];
	cof_t                    cof_s4 [NE];
	cof_t                    cof_s5 [NE];
	logic signed [CW-1:0]    pl_s3 [3];
	logic signed [CW-1:0]    ph_s3 [3];
	det_t                    term_s4 [3];
	det_t                    det_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat_s3 <= mat;
			mat_s4 <= mat_s3;
			mat_s5 <= mat_s4;
			cof_s3 <= cof;
			cof_s4 <= cof_s3;
			cof_s5 <= cof_s4;
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_term
		elem_t a0;
		assign a0 = $signed(mat.a[j]);
		always_ff @(posedge clk) begin
			if (en) begin
				// low half unsigned, high half carries the sign
				pl_s3[j]   <= a0 * $signed({1'b0, cof[j][EW-1:0]});
				ph_s3[j]   <= a0 * $signed(cof[j][CW-1:EW]);
				term_s4[j] <= (det_t'(ph_s3[j]) <<< EW) + det_t'(pl_s3[j]);
			end
		end
	end

	assign det_valid = v_s5;
	assign det_mat   = mat_s5;
	assign det_cof   = cof_s5;
	assign det       = det_s5;

endmodule

// ----- hdl/smi_div.sv -----
// Operand selection, nine restoring dividers of one bit per stage, rounding
// and saturation into the output register. Depends on smi_pkg.
module smi_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     valid,
	input  smi_pkg::mat_t            mat,
	input  smi_pkg::cof_t            cof [smi_pkg::NE],
	input  smi_pkg::det_t            det,
	output logic                     res_valid,
	output smi_pkg::elem_t           res [smi_pkg::NE],
	output logic                     res_singular,
	output logic                     res_overflow
);
	import smi_pkg::*;

	num_t                    num_c [NE];
	det_t                    den_c;
	logic                    sing_c;

	logic                    v_s6;
	num_t                    num_s6 [NE];
	det_t                    den_s6;
	logic                    sing_s6;

	logic [MAGW-1:0]         mag_c [NE];
	logic [MW-1:0]           m_c [NE];
	logic [DMW-1:0]          dmag_c;

	// index 0 is the setup stage, index QW the last divide step
	logic                    dv_v_s    [QW+1];
	logic                    dv_sing_s [QW+1];
	logic [DMW-1:0]          dv_d_s    [QW+1];
	logic [DMW-1:0]          dv_rem_s  [QW+1][NE];
	logic [QW-1:0]           dv_q_s    [QW+1][NE];
	logic                    dv_neg_s  [QW+1][NE];
	logic                    dv_ovf_s  [QW+1][NE];

	elem_t                   res_c [NE];
	logic [NE-1:0]           sat_c;

	logic                    valid_q, sing_q, ovf_q;
	elem_t                   res_q [NE];

	always_comb begin
		for (int k = 0; k < NE; k++) num_c[k] = '0;
		den_c  = '0;
		sing_c = 1'b1;
		case (mat.size)
			SIZE_1: begin
				den_c    = det_t'($signed(mat.a[0]));
				num_c[0] = num_t'(1);
				sing_c   = (mat.a[0] == '0);
			end
			SIZE_2: begin
				// the 2x2 determinant is cofactor (2,2)
				den_c    = det_t'(cof[8]);
				num_c[0] = num_t'($signed(mat.a[4]));
				num_c[1] = -num_t'($signed(mat.a[1]));
				num_c[3] = -num_t'($signed(mat.a[3]));
				num_c[4] = num_t'($signed(mat.a[0]));
				sing_c   = (cof[8] == '0);
			end
			SIZE_3: begin
				den_c = det;
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++)
						num_c[i*3+j] = num_t'(cof[j*3+i]);
				sing_c = (det == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s6  <= num_c;
			den_s6  <= den_c;
			sing_s6 <= sing_c;
		end
	end

	always_comb begin
		dmag_c = den_s6[DW-1] ? DMW'(-den_s6) : DMW'(den_s6);
		for (int k = 0; k < NE; k++) begin
			mag_c[k] = num_s6[k][NW-1] ? MAGW'(-num_s6[k]) : MAGW'(num_s6[k]);
			m_c[k]   = MW'(mag_c[k]) << SH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_d_s[0]    <= dmag_c;
			dv_sing_s[0] <= sing_s6;
			for (int k = 0; k < NE; k++) begin
				// upper part at or above the divisor: quotient needs over QW bits
				dv_rem_s[0][k] <= DMW'(m_c[k][MW-1:QW]);
				dv_q_s[0][k]   <= m_c[k][QW-1:0];
				dv_neg_s[0][k] <= num_s6[k][NW-1] ^ den_s6[DW-1];
				dv_ovf_s[0][k] <= DMW'(m_c[k][MW-1:QW]) >= dmag_c;
			end
		end
	end

	for (genvar t = 0; t < QW; t++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[t+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[t+1] <= dv_v_s[t];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_d_s[t+1]    <= dv_d_s[t];
				dv_sing_s[t+1] <= dv_sing_s[t];
			end
		end

		for (genvar k = 0; k < NE; k++) begin : g_lane
			logic [DMW:0] sh;
			logic         ge;
			// dividend bits shift out of the top of q while quotient bits enter below
			assign sh = {dv_rem_s[t][k], dv_q_s[t][k][QW-1]};
			assign ge = sh >= {1'b0, dv_d_s[t]};
			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[t+1][k] <= ge ? DMW'(sh - {1'b0, dv_d_s[t]}) : DMW'(sh);
					dv_q_s[t+1][k]   <= {dv_q_s[t][k][QW-2:0], ge};
					dv_neg_s[t+1][k] <= dv_neg_s[t][k];
					dv_ovf_s[t+1][k] <= dv_ovf_s[t][k];
				end
			end
		end
	end

	always_comb begin
		logic [QW-1:0] qr;
		logic [QW-1:0] lim;
		logic [QW-1:0] val;
		for (int k = 0; k < NE; k++) begin
			// last quotient bit rounds half away from zero
			qr       = {1'b0, dv_q_s[QW][k][QW-1:1]} + QW'(dv_q_s[QW][k][0]);
			lim      = dv_neg_s[QW][k] ? LIM_NEG : LIM_POS;
			sat_c[k] = dv_ovf_s[QW][k] || (qr > lim);
			val      = sat_c[k] ? lim : qr;
			res_c[k] = dv_neg_s[QW][k] ? EW'(-val) : EW'(val);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= dv_v_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sing_q <= dv_sing_s[QW];
			ovf_q  <= !dv_sing_s[QW] && (|sat_c);
			for (int k = 0; k < NE; k++)
				res_q[k] <= dv_sing_s[QW] ? '0 : res_c[k];
		end
	end

	assign res_valid    = valid_q;
	assign res          = res_q;
	assign res_singular = sing_q;
	assign res_overflow = ovf_q;

endmodule

// ----- hdl/small_matrix_inverse_core.sv -----
// Inverse of a 1x1, 2x2 or 3x3 signed Q16.16 matrix.
// Top level: smi_cof -> smi_det -> smi_div; depends on smi_pkg.
//
// Request channel: in_valid / in_stall carry matrix_size and a00..a22 in
// row-major order. Result channel: out_valid / out_stall carry r00..r22,
// singular and overflow. A transfer completes on a rising clk edge with valid
// high and stall low.
// The pipeline has two stages of products and cofactors, three of determinant,
// two of operand setup, 33 divide steps (one quotient bit each, nine dividers in
// parallel) and the output register.
// Throughput is one matrix per cycle while out_stall does not hold the pipeline;
// every stage then takes a new request each cycle.
// While out_valid is high and out_stall is asserted the whole pipeline holds,
// and in_stall follows so no request is taken; nothing is dropped or repeated.
// A singular matrix (zero determinant, zero a00, or size 0) returns all zero
// elements with singular set and overflow clear. Elements outside the n x n
// corner read zero.
// arst_n clears all valid bits; the first request can be taken right after.
module small_matrix_inverse_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            matrix_size,
	input  smi_pkg::elem_t        a00, a01, a02,
	input  smi_pkg::elem_t        a10, a11, a12,
	input  smi_pkg::elem_t        a20, a21, a22,
	output logic                  out_valid,
	input  logic                  out_stall,
	output smi_pkg::elem_t        r00, r01, r02,
	output smi_pkg::elem_t        r10, r11, r12,
	output smi_pkg::elem_t        r20, r21, r22,
	output logic                  singular,
	output logic                  overflow
);
	import smi_pkg::*;

	logic    en;
	mat_t    mat;
	logic    cof_valid, det_valid;
	mat_t    cof_mat, det_mat;
	cof_t    cof [NE];
	cof_t    det_cof [NE];
	det_t    det;
	elem_t   res [NE];

	// hold every stage while a finished result waits
	assign en       = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;

	assign mat.size = matrix_size;
	assign mat.a[0] = a00;
	assign mat.a[1] = a01;
	assign mat.a[2] = a02;
	assign mat.a[3] = a10;
	assign mat.a[4] = a11;
	assign mat.a[5] = a12;
	assign mat.a[6] = a20;
	assign mat.a[7] = a21;
	assign mat.a[8] = a22;

	smi_cof u_cof (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (in_valid),
		.mat       (mat),
		.cof_valid (cof_valid),
		.cof_mat   (cof_mat),
		.cof       (cof)
	);

	smi_det u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (cof_valid),
		.mat       (cof_mat),
		.cof       (cof),
		.det_valid (det_valid),
		.det_mat   (det_mat),
		.det_cof   (det_cof),
		.det       (det)
	);

	smi_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.valid        (det_valid),
		.mat          (det_mat),
		.cof          (det_cof),
		.det          (det),
		.res_valid    (out_valid),
		.res          (res),
		.res_singular (singular),
		.res_overflow (overflow)
	);

	assign r00 = res[0];
	assign r01 = res[1];
	assign r02 = res[2];
	assign r10 = res[3];
	assign r11 = res[4];
	assign r12 = res[5];
	assign r20 = res[6];
	assign r21 = res[7];
	assign r22 = res[8];

endmodule

// ----- hdl/smi_checker.sv -----
// Port-level checks of small_matrix_inverse_core, attached by bind.
// Depends on smi_pkg.
module smi_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_stall,
	input  logic              out_valid,
	input  logic              out_stall,
	input  smi_pkg::elem_t    r00,
	input  smi_pkg::elem_t    r11,
	input  smi_pkg::elem_t    r22,
	input  logic              singular,
	input  logic              overflow
);
	import smi_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(r00) && $stable(singular) && $stable(overflow))
		else $error("stalled result changed");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> !overflow && r00 == '0 && r11 == '0 && r22 == '0)
		else $error("singular result not cleared");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stalled without a blocked result");

endmodule

bind small_matrix_inverse_core smi_checker u_smi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.r00       (r00),
	.r11       (r11),
	.r22       (r22),
	.singular  (singular),
	.overflow  (overflow)
);
